// File: rtl/jlsu_pkg.sv
// Shared types, opcode names, status codes and sizes for the load/store unit.
// No dependencies; the front end, command queue, back end and top level import this package.
`timescale 1ns / 1ps

package jlsu_pkg;

    // Storage sizes
    localparam int STACK_WORDS = 64;
    localparam int LOCAL_WORDS = 256;
    localparam int STACK_AW    = $clog2(STACK_WORDS);
    localparam int COUNT_W     = $clog2(STACK_WORDS + 1);
    localparam int LOCAL_AW    = $clog2(LOCAL_WORDS);
    // width for count + 2 and the clamped stack limit
    localparam int SUM_W       = (COUNT_W > 7 ? COUNT_W : 7) + 1;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_STACK_LIMIT  = 1'b0;
    localparam logic CFG_LOCALS_LIMIT = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OVER   = 3'd1;
    localparam logic [2:0] ST_UNDER  = 3'd2;
    localparam logic [2:0] ST_BADIDX = 3'd3;
    localparam logic [2:0] ST_UNSUP  = 3'd4;

    // Opcodes
    localparam logic [7:0] OPC_NO_OP           = 8'h00;
    localparam logic [7:0] OPC_NULL_REF        = 8'h01;
    localparam logic [7:0] OPC_INT_CONST_FIRST = 8'h02;
    localparam logic [7:0] OPC_INT_CONST_LAST  = 8'h08;
    localparam logic [7:0] OPC_LONG_ZERO       = 8'h09;
    localparam logic [7:0] OPC_LONG_ONE        = 8'h0A;
    localparam logic [7:0] OPC_FLT_ZERO        = 8'h0B;
    localparam logic [7:0] OPC_FLT_ONE         = 8'h0C;
    localparam logic [7:0] OPC_FLT_TWO         = 8'h0D;
    localparam logic [7:0] OPC_DBL_ZERO        = 8'h0E;
    localparam logic [7:0] OPC_DBL_ONE         = 8'h0F;
    localparam logic [7:0] OPC_PUSH_BYTE       = 8'h10;
    localparam logic [7:0] OPC_PUSH_SHORT      = 8'h11;
    localparam logic [7:0] OPC_LD_INT          = 8'h15;
    localparam logic [7:0] OPC_LD_LONG         = 8'h16;
    localparam logic [7:0] OPC_LD_DBL          = 8'h18;
    localparam logic [7:0] OPC_LD_REF          = 8'h19;
    localparam logic [7:0] OPC_LD_FIXED_FIRST  = 8'h1A;
    localparam logic [7:0] OPC_LD_FIXED_LAST   = 8'h2D;
    localparam logic [7:0] OPC_ST_INT          = 8'h36;
    localparam logic [7:0] OPC_ST_LONG         = 8'h37;
    localparam logic [7:0] OPC_ST_DBL          = 8'h39;
    localparam logic [7:0] OPC_ST_REF          = 8'h3A;
    localparam logic [7:0] OPC_ST_FIXED_FIRST  = 8'h3B;
    localparam logic [7:0] OPC_ST_FIXED_LAST   = 8'h4E;

    // Constant bit patterns
    localparam logic [31:0] INT_CONST_BIAS = 32'd3;
    localparam logic [31:0] FLOAT_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_TWO      = 32'h4000_0000;
    localparam logic [31:0] DOUBLE_ONE     = 32'h3FF0_0000;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_LOAD,
        CMD_STORE
    } cmd_kind_t;

    // Classified request handed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic        two;      // two-word value
        logic [2:0]  status;   // fault found at decode, else ST_OK
        logic [1:0]  adv;
        logic [7:0]  idx;
        logic [31:0] hi;       // pushed first
        logic [31:0] lo;       // pushed second, ends on top
    } cmd_t;

endpackage

// File: rtl/jlsu_req_if.sv
// Request channel: opcode byte and the two following code bytes.
// Depends on nothing.
`timescale 1ns / 1ps

interface jlsu_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  operation;
    logic [15:0] operand_bytes;

    modport source (output valid, output operation, output operand_bytes, input ready);
    modport sink (input valid, input operation, input operand_bytes, output ready);
endinterface

// File: rtl/jlsu_rsp_if.sv
// Result channel: status, pc advance and the top of the operand stack.
// Depends on nothing.
`timescale 1ns / 1ps

interface jlsu_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  pc_advance;
    logic [6:0]  stack_depth;
    logic [31:0] top_word;
    logic [31:0] second_word;

    modport source (output valid, output status, output pc_advance, output stack_depth,
                    output top_word, output second_word, input ready);
    modport sink (input valid, input status, input pc_advance, input stack_depth,
                  input top_word, input second_word, output ready);
endinterface

// File: rtl/jlsu_front.sv
// Front end: accepts requests and decodes each opcode into a command.
// Depends on jlsu_pkg and jlsu_req_if.
`timescale 1ns / 1ps

module jlsu_front (
    jlsu_req_if.sink        req,
    input  logic [8:0]      locals_limit,
    output logic            push_valid,
    output jlsu_pkg::cmd_t  push_cmd,
    input  logic            push_ready
);
    import jlsu_pkg::*;

    logic [7:0]  op;
    logic [15:0] ob;
    logic [7:0]  b0;
    logic [7:0]  t_ld;
    logic [7:0]  t_st;
    logic [8:0]  loc_cap;
    logic [9:0]  idx_end;
    cmd_t        cmd;

    assign op = req.operation;
    assign ob = req.operand_bytes;
    assign b0 = ob[15:8];
    assign t_ld = op - OPC_LD_FIXED_FIRST;
    assign t_st = op - OPC_ST_FIXED_FIRST;
    assign loc_cap = (locals_limit > 9'(LOCAL_WORDS)) ? 9'(LOCAL_WORDS) : locals_limit;

    always_comb
    begin
        cmd.kind   = CMD_NONE;
        cmd.two    = 1'b0;
        cmd.status = ST_OK;
        cmd.adv    = 2'd0;
        cmd.idx    = b0;
        cmd.hi     = 32'd0;
        cmd.lo     = 32'd0;
        if (op == OPC_NO_OP)
        begin
            cmd.kind = CMD_NONE;
        end
        else if (op == OPC_NULL_REF)
        begin
            cmd.kind = CMD_PUSH;
        end
        else if (op >= OPC_INT_CONST_FIRST && op <= OPC_INT_CONST_LAST)
        begin
            cmd.kind = CMD_PUSH;
            cmd.hi   = 32'(op) - INT_CONST_BIAS;   // minus one wraps to all ones
        end
        else if (op == OPC_LONG_ZERO || op == OPC_LONG_ONE)
        begin
            cmd.kind = CMD_PUSH;
            cmd.two  = 1'b1;
            cmd.lo   = {31'd0, op == OPC_LONG_ONE};
        end
        else if (op >= OPC_FLT_ZERO && op <= OPC_FLT_TWO)
        begin
            cmd.kind = CMD_PUSH;
            cmd.hi   = (op == OPC_FLT_ONE) ? FLOAT_ONE :
                       (op == OPC_FLT_TWO) ? FLOAT_TWO : 32'd0;
        end
        else if (op == OPC_DBL_ZERO || op == OPC_DBL_ONE)
        begin
            cmd.kind = CMD_PUSH;
            cmd.two  = 1'b1;
            cmd.hi   = (op == OPC_DBL_ONE) ? DOUBLE_ONE : 32'd0;
        end
        else if (op == OPC_PUSH_BYTE)
        begin
            cmd.kind = CMD_PUSH;
            cmd.adv  = 2'd1;
            cmd.hi   = {{24{b0[7]}}, b0};
        end
        else if (op == OPC_PUSH_SHORT)
        begin
            cmd.kind = CMD_PUSH;
            cmd.adv  = 2'd2;
            cmd.hi   = {{16{ob[15]}}, ob};
        end
        else if (op >= OPC_LD_INT && op <= OPC_LD_REF)
        begin
            cmd.kind = CMD_LOAD;
            cmd.adv  = 2'd1;
            cmd.two  = (op == OPC_LD_LONG) || (op == OPC_LD_DBL);
        end
        else if (op >= OPC_LD_FIXED_FIRST && op <= OPC_LD_FIXED_LAST)
        begin
            // kinds in order i, l, f, d, a: odd kinds are two-word
            cmd.kind = CMD_LOAD;
            cmd.two  = t_ld[2];
            cmd.idx  = {6'd0, t_ld[1:0]};
        end
        else if (op >= OPC_ST_INT && op <= OPC_ST_REF)
        begin
            cmd.kind = CMD_STORE;
            cmd.adv  = 2'd1;
            cmd.two  = (op == OPC_ST_LONG) || (op == OPC_ST_DBL);
        end
        else if (op >= OPC_ST_FIXED_FIRST && op <= OPC_ST_FIXED_LAST)
        begin
            cmd.kind = CMD_STORE;
            cmd.two  = t_st[2];
            cmd.idx  = {6'd0, t_st[1:0]};
        end
        else
        begin
            cmd.status = ST_UNSUP;
        end

        idx_end = 10'(cmd.idx) + (cmd.two ? 10'd2 : 10'd1);
        if ((cmd.kind == CMD_LOAD || cmd.kind == CMD_STORE) && idx_end > 10'(loc_cap))
        begin
            cmd.status = ST_BADIDX;
        end
    end

    assign push_valid = req.valid;
    assign push_cmd   = cmd;
    assign req.ready  = push_ready;

endmodule

// File: rtl/jlsu_cmd_queue.sv
// Short command FIFO that decouples decode from execution.
// Depends on jlsu_pkg.
`timescale 1ns / 1ps

module jlsu_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  jlsu_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    output logic            pop_valid,
    output jlsu_pkg::cmd_t  pop_cmd,
    input  logic            pop
);
    import jlsu_pkg::*;

    cmd_t              slots_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QAW-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/jlsu_back.sv
// Back end: runs commands against the operand stack and local-variable memories
// and drives the result register. Depends on jlsu_pkg and jlsu_rsp_if.
`timescale 1ns / 1ps

module jlsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [6:0]      stack_limit,
    input  logic            q_valid,
    input  jlsu_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    jlsu_rsp_if.source      rsp
);
    import jlsu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PUSH_LO,
        S_LD_W0,
        S_LD_W1,
        S_ST_W0,
        S_ST_W1,
        S_RD_TOP,
        S_RD_SEC,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [2:0]          status_reg, status_next;
    logic [31:0]         top_reg, top_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          out_status_reg, out_status_next;
    logic [1:0]          out_adv_reg, out_adv_next;
    logic [6:0]          out_depth_reg, out_depth_next;
    logic [31:0]         out_top_reg, out_top_next;
    logic [31:0]         out_second_reg, out_second_next;

    // operand stack: single port, registered read
    logic [31:0]         stack_mem [STACK_WORDS];
    logic [31:0]         stk_rdata_reg;
    logic                stk_we;
    logic [STACK_AW-1:0] stk_addr;
    logic [31:0]         stk_wdata;

    // local variables: single port, registered read; unwritten words read zero
    logic [31:0]         local_mem [LOCAL_WORDS];
    logic [LOCAL_WORDS-1:0] loc_valid_reg;
    logic [31:0]         loc_rdata_reg;
    logic                loc_rvld_reg;
    logic                loc_we;
    logic [LOCAL_AW-1:0] loc_addr;
    logic [31:0]         loc_data;

    logic [SUM_W-1:0]    cnt_ext;
    logic [SUM_W-1:0]    n_words;
    logic [SUM_W-1:0]    cap;
    logic [COUNT_W-1:0]  cnt_p1, cnt_p2, cnt_m1, cnt_m2, cnt_mn;
    logic [7:0]          idx_p1;

    assign cnt_ext = SUM_W'(count_reg);
    assign n_words = cmd_reg.two ? SUM_W'(2) : SUM_W'(1);
    assign cap     = (SUM_W'(stack_limit) > SUM_W'(STACK_WORDS)) ? SUM_W'(STACK_WORDS)
                                                                : SUM_W'(stack_limit);
    assign cnt_p1  = count_reg + COUNT_W'(1);
    assign cnt_p2  = count_reg + COUNT_W'(2);
    assign cnt_m1  = count_reg - COUNT_W'(1);
    assign cnt_m2  = count_reg - COUNT_W'(2);
    assign cnt_mn  = cmd_reg.two ? cnt_m2 : cnt_m1;
    assign idx_p1  = cmd_reg.idx + 8'd1;
    assign loc_data = loc_rvld_reg ? loc_rdata_reg : 32'd0;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_adv_next    = out_adv_reg;
        out_depth_next  = out_depth_reg;
        out_top_next    = out_top_reg;
        out_second_next = out_second_reg;
        q_pop     = 1'b0;
        stk_we    = 1'b0;
        stk_addr  = count_reg[STACK_AW-1:0];
        stk_wdata = cmd_reg.hi;
        loc_we    = 1'b0;
        loc_addr  = cmd_reg.idx[LOCAL_AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                status_next = cmd_reg.status;
                state_next  = S_RD_TOP;
                if (cmd_reg.status == ST_OK)
                begin
                    case (cmd_reg.kind)
                        CMD_PUSH:
                        begin
                            if (cnt_ext + n_words > cap)
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                stk_we = 1'b1;
                                if (cmd_reg.two)
                                begin
                                    state_next = S_PUSH_LO;
                                end
                                else
                                begin
                                    count_next = cnt_p1;
                                end
                            end
                        end
                        CMD_LOAD:
                        begin
                            if (cnt_ext + n_words > cap)
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                state_next = S_LD_W0;
                            end
                        end
                        CMD_STORE:
                        begin
                            if (cnt_ext < n_words)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                stk_addr   = cnt_mn[STACK_AW-1:0];
                                state_next = S_ST_W0;
                            end
                        end
                        default:
                        begin
                            state_next = S_RD_TOP;
                        end
                    endcase
                end
            end
            S_PUSH_LO:
            begin
                stk_we     = 1'b1;
                stk_addr   = cnt_p1[STACK_AW-1:0];
                stk_wdata  = cmd_reg.lo;
                count_next = cnt_p2;
                state_next = S_RD_TOP;
            end
            S_LD_W0:
            begin
                stk_we    = 1'b1;
                stk_wdata = loc_data;
                if (cmd_reg.two)
                begin
                    loc_addr   = idx_p1[LOCAL_AW-1:0];
                    state_next = S_LD_W1;
                end
                else
                begin
                    count_next = cnt_p1;
                    state_next = S_RD_TOP;
                end
            end
            S_LD_W1:
            begin
                stk_we     = 1'b1;
                stk_addr   = cnt_p1[STACK_AW-1:0];
                stk_wdata  = loc_data;
                count_next = cnt_p2;
                state_next = S_RD_TOP;
            end
            S_ST_W0:
            begin
                loc_we = 1'b1;
                if (cmd_reg.two)
                begin
                    stk_addr   = cnt_m1[STACK_AW-1:0];
                    state_next = S_ST_W1;
                end
                else
                begin
                    count_next = cnt_m1;
                    state_next = S_RD_TOP;
                end
            end
            S_ST_W1:
            begin
                loc_we     = 1'b1;
                loc_addr   = idx_p1[LOCAL_AW-1:0];
                count_next = cnt_m2;
                state_next = S_RD_TOP;
            end
            S_RD_TOP:
            begin
                stk_addr   = cnt_m1[STACK_AW-1:0];
                state_next = S_RD_SEC;
            end
            S_RD_SEC:
            begin
                top_next   = (count_reg != '0) ? stk_rdata_reg : 32'd0;
                stk_addr   = cnt_m2[STACK_AW-1:0];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // keep the second-word read in place while the result waits
                stk_addr = cnt_m2[STACK_AW-1:0];
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_adv_next    = cmd_reg.adv;
                    out_depth_next  = 7'(count_reg);
                    out_top_next    = top_reg;
                    out_second_next = (count_reg > COUNT_W'(1)) ? stk_rdata_reg : 32'd0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            loc_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (loc_we)
            begin
                loc_valid_reg[loc_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        status_reg     <= status_next;
        top_reg        <= top_next;
        out_status_reg <= out_status_next;
        out_adv_reg    <= out_adv_next;
        out_depth_reg  <= out_depth_next;
        out_top_reg    <= out_top_next;
        out_second_reg <= out_second_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_addr] <= stk_wdata;
        end
        stk_rdata_reg <= stack_mem[stk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (loc_we)
        begin
            local_mem[loc_addr] <= stk_rdata_reg;
        end
        loc_rdata_reg <= local_mem[loc_addr];
        loc_rvld_reg  <= loc_valid_reg[loc_addr];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.pc_advance  = out_adv_reg;
    assign rsp.stack_depth = out_depth_reg;
    assign rsp.top_word    = out_top_reg;
    assign rsp.second_word = out_second_reg;

endmodule

// File: rtl/jlsu_load_store_unit_core.sv
// Top level of the load/store unit: configuration registers, front end, command
// queue and back end. Depends on jlsu_pkg, jlsu_req_if, jlsu_rsp_if and submodules.
`timescale 1ns / 1ps

// Executes constant, load and store bytecodes on a 64-word operand stack and a
// 256-word local-variable file. A request is decoded in the cycle it is taken and
// queued (two entries), so the request side keeps accepting while the back end
// works and a result waits in the output register, as long as the queue has room.
// In the back end a nop or a faulting request goes from the start state straight to
// the reads; a one-word constant is written in the start state, a two-word constant
// adds S_PUSH_LO, and a load or store adds one state per word moved, since the
// single-port stack and local memories move one word per cycle. Two stack reads
// then fetch the top two words for the result. Locals read as zero until written
// (per-word valid flags cleared at reset), so no clearing pass is needed. A fault
// leaves stack and locals unchanged and still reports the opcode's operand length.
module jvm_load_store_unit_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_index,
    input  logic [8:0] cfg_wdata,
    jlsu_req_if.sink   req,
    jlsu_rsp_if.source rsp
);
    import jlsu_pkg::*;

    logic [6:0] stack_limit_reg;
    logic [8:0] locals_limit_reg;
    logic       push_valid;
    cmd_t       push_cmd;
    logic       push_ready;
    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_limit_reg  <= 7'd64;
            locals_limit_reg <= 9'd256;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_STACK_LIMIT:  stack_limit_reg  <= cfg_wdata[6:0];
                CFG_LOCALS_LIMIT: locals_limit_reg <= cfg_wdata;
                default:          stack_limit_reg  <= stack_limit_reg;
            endcase
        end
    end

    jlsu_front u_front (
        .req          (req),
        .locals_limit (locals_limit_reg),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .push_ready   (push_ready)
    );

    jlsu_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    jlsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stack_limit (stack_limit_reg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule
